>>> rtl/fol_pkg.sv
// Shared constants for the frequency-ordered lookup table.
package fol_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int COUNT_WIDTH_DEF = 16;

    localparam int KEY_W     = 8;
    localparam int LEN_W     = 5;
    localparam int POS_OUT_W = 4;
    localparam int CNT_OUT_W = 16;

    localparam logic [LEN_W-1:0] LEN_RESET = 5'd16;

endpackage

>>> rtl/freq_ordered_list_lookup.sv
// Top level: frequency-count self-organizing lookup table with its sequencer.
//
//  Channel        | Handshake                     | Payload
//  ---------------+-------------------------------+---------------------------------------
//  lookup in      | key_valid / key_stall         | search_key
//  result out     | result_valid / result_stall   | found, new_count, old/new_position
//  config write   | active_length_we              | active_length_data
//
// One table entry is read per cycle from a single RAM port, both for the search and
// for the backward shift walk. A match is shifted back past entries of equal or
// smaller count and then written at its new place; a miss goes straight to the result.
// Reset leaves the table at values 1..N with zero counts and the length at 16.
// A stalled result is held while the next lookup is searched; a new key is taken
// only when the sequencer is idle.
module freq_ordered_list_lookup #(
    parameter int TABLE_DEPTH = fol_pkg::TABLE_DEPTH_DEF,
    parameter int COUNT_WIDTH = fol_pkg::COUNT_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          key_valid,
    output logic                          key_stall,
    input  logic [fol_pkg::KEY_W-1:0]     search_key,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic                          found,
    output logic [fol_pkg::CNT_OUT_W-1:0] new_count,
    output logic [fol_pkg::POS_OUT_W-1:0] old_position,
    output logic [fol_pkg::POS_OUT_W-1:0] new_position,
    input  logic                          active_length_we,
    input  logic [fol_pkg::LEN_W-1:0]     active_length_data
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int PW = $clog2(TABLE_DEPTH + 1);
    localparam int LW = (PW > fol_pkg::LEN_W) ? PW : fol_pkg::LEN_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SRCH  = 3'd1;
    localparam logic [2:0] S_SHIFT = 3'd2;
    localparam logic [2:0] S_PLACE = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    logic [2:0]                  state_reg, state_next;
    logic [fol_pkg::LEN_W-1:0]   active_length_reg;
    logic [fol_pkg::KEY_W-1:0]   key_reg, key_next;
    logic [AW-1:0]               idx_reg, idx_next;
    logic [AW-1:0]               dest_reg, dest_next;
    logic [AW-1:0]               pos_reg, pos_next;
    logic [fol_pkg::KEY_W-1:0]   val_reg, val_next;
    logic [COUNT_WIDTH-1:0]      cnt_reg, cnt_next;
    logic [PW-1:0]               limit_reg, limit_next;
    logic                        hit_reg, hit_next;

    logic                          result_valid_reg, result_valid_next;
    logic                          found_reg, found_next;
    logic [fol_pkg::CNT_OUT_W-1:0] new_count_reg, new_count_next;
    logic [fol_pkg::POS_OUT_W-1:0] old_pos_reg, old_pos_next;
    logic [fol_pkg::POS_OUT_W-1:0] new_pos_reg, new_pos_next;

    logic                        rd_en;
    logic [AW-1:0]               rd_addr;
    logic [fol_pkg::KEY_W-1:0]   rd_value;
    logic [COUNT_WIDTH-1:0]      rd_count;
    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic [fol_pkg::KEY_W-1:0]   wr_value;
    logic [COUNT_WIDTH-1:0]      wr_count;

    logic [LW-1:0]               len_ext;
    logic [PW-1:0]               limit_calc;

    fol_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_value (rd_value),
        .rd_count (rd_count),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_value (wr_value),
        .wr_count (wr_count)
    );

    // Lengths above the table depth clamp to the depth.
    always_comb
    begin
        len_ext = LW'(active_length_reg);
        if (len_ext > LW'(TABLE_DEPTH))
        begin
            limit_calc = PW'(TABLE_DEPTH);
        end
        else
        begin
            limit_calc = PW'(len_ext);
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        key_next          = key_reg;
        idx_next          = idx_reg;
        dest_next         = dest_reg;
        pos_next          = pos_reg;
        val_next          = val_reg;
        cnt_next          = cnt_reg;
        limit_next        = limit_reg;
        hit_next          = hit_reg;
        result_valid_next = result_valid_reg && result_stall;
        found_next        = found_reg;
        new_count_next    = new_count_reg;
        old_pos_next      = old_pos_reg;
        new_pos_next      = new_pos_reg;
        rd_en             = 1'b0;
        rd_addr           = '0;
        wr_en             = 1'b0;
        wr_addr           = dest_reg;
        wr_value          = val_reg;
        wr_count          = cnt_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (key_valid)
                begin
                    key_next   = search_key;
                    idx_next   = '0;
                    limit_next = limit_calc;
                    if (limit_calc == '0)
                    begin
                        hit_next   = 1'b0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = '0;
                        state_next = S_SRCH;
                    end
                end
            end

            S_SRCH:
            begin
                // The read data belongs to entry idx_reg.
                if (rd_value == key_reg)
                begin
                    pos_next  = idx_reg;
                    dest_next = idx_reg;
                    val_next  = rd_value;
                    cnt_next  = (rd_count == COUNT_MAX) ? rd_count
                                                        : rd_count + COUNT_WIDTH'(1);
                    if (idx_reg == '0)
                    begin
                        state_next = S_PLACE;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = idx_reg - AW'(1);
                        state_next = S_SHIFT;
                    end
                end
                else if (PW'(idx_reg) + PW'(1) == limit_reg)
                begin
                    hit_next   = 1'b0;
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                    rd_en    = 1'b1;
                    rd_addr  = idx_reg + AW'(1);
                end
            end

            S_SHIFT:
            begin
                // The read data belongs to the entry just ahead of dest_reg.
                if (rd_count <= cnt_reg)
                begin
                    wr_en     = 1'b1;
                    wr_addr   = dest_reg;
                    wr_value  = rd_value;
                    wr_count  = rd_count;
                    dest_next = dest_reg - AW'(1);
                    if (dest_reg == AW'(1))
                    begin
                        state_next = S_PLACE;
                    end
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = dest_reg - AW'(2);
                    end
                end
                else
                begin
                    state_next = S_PLACE;
                end
            end

            S_PLACE:
            begin
                wr_en      = 1'b1;
                wr_addr    = dest_reg;
                wr_value   = val_reg;
                wr_count   = cnt_reg;
                hit_next   = 1'b1;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_valid_next = 1'b1;
                    found_next        = hit_reg;
                    if (hit_reg)
                    begin
                        new_count_next = fol_pkg::CNT_OUT_W'(cnt_reg);
                        old_pos_next   = fol_pkg::POS_OUT_W'(pos_reg);
                        new_pos_next   = fol_pkg::POS_OUT_W'(dest_reg);
                    end
                    else
                    begin
                        new_count_next = '0;
                        old_pos_next   = '0;
                        new_pos_next   = '0;
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            active_length_reg <= fol_pkg::LEN_RESET;
            result_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
            if (active_length_we)
            begin
                active_length_reg <= active_length_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg       <= key_next;
        idx_reg       <= idx_next;
        dest_reg      <= dest_next;
        pos_reg       <= pos_next;
        val_reg       <= val_next;
        cnt_reg       <= cnt_next;
        limit_reg     <= limit_next;
        hit_reg       <= hit_next;
        found_reg     <= found_next;
        new_count_reg <= new_count_next;
        old_pos_reg   <= old_pos_next;
        new_pos_reg   <= new_pos_next;
    end

    assign key_stall    = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign found        = found_reg;
    assign new_count    = new_count_reg;
    assign old_position = old_pos_reg;
    assign new_position = new_pos_reg;

endmodule

>>> rtl/fol_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fol_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/fol_table.sv
// Entry store: value and count RAM with per-entry valid bits for reset contents.
module fol_table #(
    parameter int TABLE_DEPTH = fol_pkg::TABLE_DEPTH_DEF,
    parameter int COUNT_WIDTH = fol_pkg::COUNT_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           rd_en,
    input  logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
    output logic [fol_pkg::KEY_W-1:0]      rd_value,
    output logic [COUNT_WIDTH-1:0]         rd_count,
    input  logic                           wr_en,
    input  logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
    input  logic [fol_pkg::KEY_W-1:0]      wr_value,
    input  logic [COUNT_WIDTH-1:0]         wr_count
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int DW = fol_pkg::KEY_W + COUNT_WIDTH;

    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [TABLE_DEPTH-1:0] valid_next;
    logic                   rd_valid_reg;
    logic [AW-1:0]          rd_addr_reg;
    logic [DW-1:0]          ram_rdata;

    fol_ram #(
        .WIDTH (DW),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata ({wr_value, wr_count}),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        valid_next = valid_reg;
        if (wr_en)
        begin
            valid_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_addr_reg <= rd_addr;
        end
    end

    // An entry never written still holds its reset contents: position plus one, count zero.
    always_comb
    begin
        if (rd_valid_reg)
        begin
            rd_value = ram_rdata[DW-1:COUNT_WIDTH];
            rd_count = ram_rdata[COUNT_WIDTH-1:0];
        end
        else
        begin
            rd_value = fol_pkg::KEY_W'(rd_addr_reg) + fol_pkg::KEY_W'(1);
            rd_count = '0;
        end
    end

endmodule
